### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the arbiter sequencer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### sv/zppa_pkg.sv
// ----------------------------------------------------------------------------
// zppa_pkg
// types, codes and helpers of the zone priority preempt arbiter
// ----------------------------------------------------------------------------
package zppa_pkg;

   localparam int FUNCS_PER_ZONE_DEF = 16;
   localparam int ZONE_COUNT_DEF     = 3;
   localparam int PRIORITY_BITS_DEF  = 4;

   localparam int FN_W       = 5;
   localparam int ZONE_W     = 2;
   localparam int OP_W       = 2;
   localparam int ST_W       = 2;
   localparam int CODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PRES_W     = 16;

   typedef enum logic [OP_W-1:0] {
      OP_REQUEST = 2'd0,
      OP_STATUS  = 2'd1,
      OP_READY   = 2'd2,
      OP_FLAG    = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_INIT  = 2'd0,
      ST_READY = 2'd1,
      ST_PLAY  = 2'd2,
      ST_END   = 2'd3
   } status_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_OK        = 3'd0,
      CODE_OWNER     = 3'd1,
      CODE_OWNER_PND = 3'd2,
      CODE_BUSY      = 3'd3,
      CODE_UNKNOWN   = 3'd4,
      CODE_NOT_OWNER = 3'd5,
      CODE_IGNORED   = 3'd6
   } code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_A_PRESENT = 3'd0,
      REG_A_PRIO    = 3'd1,
      REG_B_PRESENT = 3'd2,
      REG_B_PRIO    = 3'd3,
      REG_C_PRESENT = 3'd4,
      REG_C_PRIO    = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   // one above the highest set bit, zero for an empty mask
   function automatic logic [FN_W-1:0] idle_of(input logic [PRES_W-1:0] mask);
      logic [FN_W-1:0] n;
      n = '0;
      for (int i = 0; i < PRES_W; i++) begin
         if (mask[i]) begin
            n = FN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

### sv/zppa_ctrl.sv
// ----------------------------------------------------------------------------
// zppa_ctrl
// sequencer: capture a request, apply it, hold the response
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zppa_ctrl
   import zppa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);

   `ASSERT_NEXT(a_load_then_exec, clock, reset, cmd.load, cmd.exec)
   `ASSERT_NEXT(a_exec_then_rsp, clock, reset, cmd.exec, rsp_valid)
   `ASSERT_SAME(a_no_take_while_rsp, clock, reset, rsp_valid, req_stall && !cmd.load)

endmodule

### sv/zppa_dpath.sv
// ----------------------------------------------------------------------------
// zppa_dpath
// tables, per-zone ownership state and the operation logic
// ----------------------------------------------------------------------------
module zppa_dpath
   import zppa_pkg::*;
#(
   parameter int FUNCS_PER_ZONE = FUNCS_PER_ZONE_DEF,
   parameter int ZONE_COUNT     = ZONE_COUNT_DEF,
   parameter int PRIORITY_BITS  = PRIORITY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [OP_W-1:0]       req_func,
   input  logic [ZONE_W-1:0]     req_zone,
   input  logic [FN_W-1:0]       req_function_sn,
   input  logic [ST_W-1:0]       req_new_status,
   input  logic                  req_flag_value,
   output logic [CODE_W-1:0]     rsp_code,
   output logic [FN_W-1:0]       rsp_current_function,
   output logic [ST_W-1:0]       rsp_show_status,
   output logic                  rsp_preempt_pending,
   output logic [FN_W-1:0]       rsp_preempt_function
);

   localparam int ZIW   = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int FIW   = $clog2(FUNCS_PER_ZONE);
   localparam int PRI_W = FUNCS_PER_ZONE * PRIORITY_BITS;

   // configuration tables
   logic [FUNCS_PER_ZONE-1:0] present_ff [ZONE_COUNT];
   logic [PRI_W-1:0]          prio_ff    [ZONE_COUNT];

   // zone state
   logic [FN_W-1:0] owner_ff   [ZONE_COUNT];
   status_type      status_ff  [ZONE_COUNT];
   logic            flag_ff    [ZONE_COUNT];
   logic [FN_W-1:0] pend_fn_ff [ZONE_COUNT];

   // captured request
   op_type          op_ff;
   logic [ZONE_W-1:0] zone_ff;
   logic [FN_W-1:0] sn_ff;
   status_type      new_st_ff;
   logic            fv_ff;

   // response registers
   code_type        code_ff;
   logic [FN_W-1:0] cur_fn_ff;
   status_type      show_st_ff;
   logic            pend_ff;
   logic [FN_W-1:0] pend_out_ff;

   // config decode
   logic                  cfg_ok;
   logic [ZONE_W-1:0]     cfg_zone;
   logic [ZIW-1:0]        cz;
   logic [FN_W-1:0]       cfg_idle;

   // operation logic
   logic                  zone_ok;
   logic [ZIW-1:0]        zi;
   logic [FN_W-1:0]       o;
   status_type            st;
   logic                  fl;
   logic [FN_W-1:0]       pf;
   logic [FUNCS_PER_ZONE-1:0] pres;
   logic [PRI_W-1:0]      prio;
   logic [FN_W-1:0]       idle;
   logic                  sn_in, o_in;
   logic [PRIORITY_BITS-1:0] sn_pri, o_pri;
   logic [FN_W-1:0]       n_o;
   status_type            n_st;
   logic                  n_fl;
   logic [FN_W-1:0]       n_pf;
   code_type              n_code;

   assign cfg_zone = csr_index[CSR_IDX_W-1:1];
   assign cz       = cfg_zone[ZIW-1:0];
   assign cfg_ok   = (csr_index <= REG_C_PRIO) && (cfg_zone < ZONE_W'(ZONE_COUNT));
   assign cfg_idle = idle_of(PRES_W'(csr_data[FUNCS_PER_ZONE-1:0]));

   assign zone_ok = (zone_ff < ZONE_W'(ZONE_COUNT));
   assign zi      = zone_ff[ZIW-1:0];

   always_comb begin
      o    = owner_ff[zi];
      st   = status_ff[zi];
      fl   = flag_ff[zi];
      pf   = pend_fn_ff[zi];
      pres = present_ff[zi];
      prio = prio_ff[zi];
      idle = idle_of(PRES_W'(pres));
      // functions past the table are never present
      sn_in  = (sn_ff < FN_W'(FUNCS_PER_ZONE)) && pres[sn_ff[FIW-1:0]];
      o_in   = (o < FN_W'(FUNCS_PER_ZONE)) && pres[o[FIW-1:0]];
      sn_pri = prio[int'(sn_ff[FIW-1:0]) * PRIORITY_BITS +: PRIORITY_BITS];
      o_pri  = prio[int'(o[FIW-1:0]) * PRIORITY_BITS +: PRIORITY_BITS];
   end

   always_comb begin
      n_o    = o;
      n_st   = st;
      n_fl   = fl;
      n_pf   = pf;
      n_code = CODE_OK;
      case (op_ff)
         OP_REQUEST: begin
            if (st == ST_READY) begin
               n_o  = sn_ff;
               n_st = ST_PLAY;
               n_fl = 1'b0;
               n_pf = idle;
            end else if (o == sn_ff) begin
               n_code = fl ? CODE_OWNER_PND : CODE_OWNER;
            end else if (!sn_in || !o_in) begin
               n_code = CODE_UNKNOWN;
            end else begin
               if (sn_pri < o_pri) begin
                  n_fl = 1'b1;
                  n_pf = sn_ff;
               end
               n_code = CODE_BUSY;
            end
         end
         OP_STATUS: begin
            if (sn_ff != o) begin
               n_code = CODE_NOT_OWNER;
            end else begin
               n_st = new_st_ff;
               n_fl = 1'b0;
               n_pf = idle;
            end
         end
         OP_READY: begin
            if (st == ST_END || st == ST_INIT) begin
               n_o  = idle;
               n_st = ST_READY;
               n_fl = 1'b0;
               n_pf = idle;
            end else begin
               n_code = CODE_IGNORED;
            end
         end
         OP_FLAG: begin
            n_fl = fv_ff;
         end
         default: begin
            n_code = CODE_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONE_COUNT; z++) begin
            present_ff[z] <= '0;
            prio_ff[z]    <= '0;
            owner_ff[z]   <= '0;
            status_ff[z]  <= ST_INIT;
            flag_ff[z]    <= 1'b0;
            pend_fn_ff[z] <= '0;
         end
      end else begin
         if (csr_write && cfg_ok) begin
            if (!csr_index[0]) begin
               // new table reinitializes the zone
               present_ff[cz] <= csr_data[FUNCS_PER_ZONE-1:0];
               owner_ff[cz]   <= cfg_idle;
               status_ff[cz]  <= ST_INIT;
               flag_ff[cz]    <= 1'b0;
               pend_fn_ff[cz] <= cfg_idle;
            end else begin
               prio_ff[cz] <= csr_data[PRI_W-1:0];
            end
         end
         if (cmd.exec && zone_ok) begin
            owner_ff[zi]   <= n_o;
            status_ff[zi]  <= n_st;
            flag_ff[zi]    <= n_fl;
            pend_fn_ff[zi] <= n_pf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_func);
         zone_ff   <= req_zone;
         sn_ff     <= req_function_sn;
         new_st_ff <= status_type'(req_new_status);
         fv_ff     <= req_flag_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (zone_ok) begin
            code_ff     <= n_code;
            cur_fn_ff   <= n_o;
            show_st_ff  <= n_st;
            pend_ff     <= n_fl;
            pend_out_ff <= n_pf;
         end else begin
            code_ff     <= CODE_IGNORED;
            cur_fn_ff   <= '0;
            show_st_ff  <= ST_INIT;
            pend_ff     <= 1'b0;
            pend_out_ff <= '0;
         end
      end
   end

   assign rsp_code             = code_ff;
   assign rsp_current_function = cur_fn_ff;
   assign rsp_show_status      = show_st_ff;
   assign rsp_preempt_pending  = pend_ff;
   assign rsp_preempt_function = pend_out_ff;

endmodule

### sv/zone_priority_preempt_arbiter.sv
// a request taken in idle is captured, then applied in exec and answered in resp (rsp_valid)
// the capture/apply/respond sequencer takes no new request until the last response is taken
// a stalled response holds the sequencer, and with it req_stall, until it is taken
// reset (synchronous, active high): all tables and zone state clear to zero, idle numbers are 0
// ----------------------------------------------------------------------------
// zone_priority_preempt_arbiter
// per-zone ownership arbiter with priority preemption for up to three zones
// ----------------------------------------------------------------------------
module zone_priority_preempt_arbiter
   import zppa_pkg::*;
#(
   parameter int FUNCS_PER_ZONE = FUNCS_PER_ZONE_DEF,
   parameter int ZONE_COUNT     = ZONE_COUNT_DEF,
   parameter int PRIORITY_BITS  = PRIORITY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_func,
   input  logic [ZONE_W-1:0]     req_zone,
   input  logic [FN_W-1:0]       req_function_sn,
   input  logic [ST_W-1:0]       req_new_status,
   input  logic                  req_flag_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_code,
   output logic [FN_W-1:0]       rsp_current_function,
   output logic [ST_W-1:0]       rsp_show_status,
   output logic                  rsp_preempt_pending,
   output logic [FN_W-1:0]       rsp_preempt_function
);

   // commands from the sequencer into the datapath
   dp_cmd_type cmd;

   // sequencer: idle -> apply -> respond
   zppa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // tables, zone state, operation logic and response registers
   zppa_dpath #(
      .FUNCS_PER_ZONE (FUNCS_PER_ZONE),
      .ZONE_COUNT     (ZONE_COUNT),
      .PRIORITY_BITS  (PRIORITY_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_func             (req_func),
      .req_zone             (req_zone),
      .req_function_sn      (req_function_sn),
      .req_new_status       (req_new_status),
      .req_flag_value       (req_flag_value),
      .rsp_code             (rsp_code),
      .rsp_current_function (rsp_current_function),
      .rsp_show_status      (rsp_show_status),
      .rsp_preempt_pending  (rsp_preempt_pending),
      .rsp_preempt_function (rsp_preempt_function)
   );

endmodule

### tb/sv/zone_owner_checker.sv
// ----------------------------------------------------------------------------
// zone_owner_checker
// tracks zone ownership from accepted requests and table writes, predicts
// each zone report and compares it with the response channel
// ----------------------------------------------------------------------------
module zone_owner_checker
   import zppa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [OP_W-1:0]       req_func,
   input  logic [ZONE_W-1:0]     req_zone,
   input  logic [FN_W-1:0]       req_function_sn,
   input  logic [ST_W-1:0]       req_new_status,
   input  logic                  req_flag_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CODE_W-1:0]     rsp_code,
   input  logic [FN_W-1:0]       rsp_current_function,
   input  logic [ST_W-1:0]       rsp_show_status,
   input  logic                  rsp_preempt_pending,
   input  logic [FN_W-1:0]       rsp_preempt_function,
   output int                    failures,
   output int                    outstanding,
   output int                    checked,
   output logic [6:0]            codes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      code_type        code;
      logic [FN_W-1:0] owner;
      status_type      status;
      logic            pending;
      logic [FN_W-1:0] waiter;
   } zone_report_type;

   logic [PRES_W-1:0]     table_present [ZONE_COUNT_DEF];
   logic [CSR_DATA_W-1:0] table_prio    [ZONE_COUNT_DEF];
   logic [FN_W-1:0]       zone_owner    [ZONE_COUNT_DEF];
   status_type            zone_state    [ZONE_COUNT_DEF];
   logic                  zone_flag     [ZONE_COUNT_DEF];
   logic [FN_W-1:0]       zone_waiter   [ZONE_COUNT_DEF];

   zone_report_type expected_reports [$];

   // append at the tail of the expected queue
   function automatic void enqueue_report(input zone_report_type r);
      expected_reports.insert(expected_reports.size(), r);
   endfunction

   // highest present function plus one, zero for an empty table
   function automatic logic [FN_W-1:0] idle_number(input int z);
      for (int i = FUNCS_PER_ZONE_DEF - 1; i >= 0; i--) begin
         if (table_present[z][i]) begin
            return FN_W'(i + 1);
         end
      end
      return '0;
   endfunction

   function automatic logic in_table(input int z, input logic [FN_W-1:0] sn);
      return (sn < FUNCS_PER_ZONE_DEF) && table_present[z][sn[3:0]];
   endfunction

   function automatic logic [PRIORITY_BITS_DEF-1:0] urgency(input int z,
                                                           input logic [FN_W-1:0] sn);
      return table_prio[z][sn[3:0] * PRIORITY_BITS_DEF +: PRIORITY_BITS_DEF];
   endfunction

   // new owner and status, preemption cleared
   function automatic void take_zone(input int z, input status_type st,
                                     input logic [FN_W-1:0] fn);
      zone_owner[z]  = fn;
      zone_state[z]  = st;
      zone_flag[z]   = 1'b0;
      zone_waiter[z] = idle_number(z);
   endfunction

   function automatic void apply_table_write(input logic [CSR_IDX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] data);
      int z;
      if (idx > REG_C_PRIO) begin
         return;
      end
      z = idx >> 1;
      if (idx[0]) begin
         table_prio[z] = data;
      end else begin
         table_present[z] = data[PRES_W-1:0];
         take_zone(z, ST_INIT, idle_number(z));
      end
   endfunction

   function automatic zone_report_type predict_report(input op_type op,
                                                     input logic [ZONE_W-1:0] zn,
                                                     input logic [FN_W-1:0] sn,
                                                     input status_type ns,
                                                     input logic fv);
      zone_report_type r;
      int z;
      code_type code;
      if (zn >= ZONE_COUNT_DEF) begin
         r.code    = CODE_IGNORED;
         r.owner   = '0;
         r.status  = ST_INIT;
         r.pending = 1'b0;
         r.waiter  = '0;
         return r;
      end
      z = zn;
      code = CODE_OK;
      case (op)
         OP_REQUEST: begin
            if (zone_state[z] == ST_READY) begin
               take_zone(z, ST_PLAY, sn);
            end else if (zone_owner[z] == sn) begin
               code = zone_flag[z] ? CODE_OWNER_PND : CODE_OWNER;
            end else if (!in_table(z, sn) || !in_table(z, zone_owner[z])) begin
               code = CODE_UNKNOWN;
            end else begin
               if (urgency(z, sn) < urgency(z, zone_owner[z])) begin
                  zone_flag[z]   = 1'b1;
                  zone_waiter[z] = sn;
               end
               code = CODE_BUSY;
            end
         end
         OP_STATUS: begin
            if (sn != zone_owner[z]) begin
               code = CODE_NOT_OWNER;
            end else begin
               take_zone(z, ns, sn);
            end
         end
         OP_READY: begin
            if (zone_state[z] == ST_END || zone_state[z] == ST_INIT) begin
               take_zone(z, ST_READY, idle_number(z));
            end else begin
               code = CODE_IGNORED;
            end
         end
         default: begin
            zone_flag[z] = fv;
         end
      endcase
      r.code    = code;
      r.owner   = zone_owner[z];
      r.status  = zone_state[z];
      r.pending = zone_flag[z];
      r.waiter  = zone_waiter[z];
      return r;
   endfunction

   function automatic int field_diff(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      zone_report_type want;
      int fail_now;
      fail_now = 0;
      if (reset) begin
         for (int z = 0; z < ZONE_COUNT_DEF; z++) begin
            table_present[z] = '0;
            table_prio[z]    = '0;
            take_zone(z, ST_INIT, idle_number(z));
         end
         expected_reports.delete();
         failures   <= 0;
         checked    <= 0;
         codes_seen <= '0;
      end else begin
         if (csr_write) begin
            apply_table_write(csr_index, csr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("response with no request outstanding, code %0d", rsp_code);
               fail_now++;
            end else begin
               want = expected_reports.pop_front();
               fail_now += field_diff("code", want.code, rsp_code);
               fail_now += field_diff("current_function", want.owner, rsp_current_function);
               fail_now += field_diff("show_status", want.status, rsp_show_status);
               fail_now += field_diff("preempt_pending", want.pending, rsp_preempt_pending);
               fail_now += field_diff("preempt_function", want.waiter, rsp_preempt_function);
               checked    <= checked + 1;
               codes_seen <= codes_seen | (7'b1 << want.code);
            end
         end
         if (req_valid && !req_stall) begin
            enqueue_report(predict_report(op_type'(req_func), req_zone,
                                          req_function_sn,
                                          status_type'(req_new_status),
                                          req_flag_value));
         end
         failures <= failures + fail_now;
      end
      outstanding <= expected_reports.size();
   end

endmodule

### tb/sv/zone_priority_preempt_arbiter_tb.sv
// ----------------------------------------------------------------------------
// zone_priority_preempt_arbiter_tb
// drives directed and random zone requests through the arbiter under several
// table settings and random idling on both channels; the checker beside the
// block predicts every zone report and counts mismatches
// ----------------------------------------------------------------------------
module zone_priority_preempt_arbiter_tb import zppa_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no request or response taken before the run is declared hung
   localparam int QUIET_LIMIT      = 4000;
   // random requests per idling phase
   localparam int RANDOM_PER_PHASE = 500;
   // cycles allowed after the last response for anything unexpected to show up
   localparam int DRAIN_CYCLES     = 8;
   // register slot past the last table register, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd6;
   // zone number past the last zone, requests there are ignored
   localparam logic [ZONE_W-1:0]    ZONE_NONE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_func = '0;
   logic [ZONE_W-1:0]     req_zone = '0;
   logic [FN_W-1:0]       req_function_sn = '0;
   logic [ST_W-1:0]       req_new_status = '0;
   logic                  req_flag_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_code;
   logic [FN_W-1:0]       rsp_current_function;
   logic [ST_W-1:0]       rsp_show_status;
   logic                  rsp_preempt_pending;
   logic [FN_W-1:0]       rsp_preempt_function;

   int          failures;
   int          outstanding;
   int          checked;
   logic [6:0]  codes_seen;

   // idling odds in percent, changed per phase
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   int          requests_sent = 0;

   // stimulus-side copy of the present masks, used to pick likely owners
   logic [PRES_W-1:0] present_copy [ZONE_COUNT_DEF];

   zone_priority_preempt_arbiter DUT (.*);

   zone_owner_checker zone_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stalls at random, never during reset
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // hang detector: counts cycles in which neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves csr_write high so back-to-back writes need one assignment per edge
   task automatic write_table(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
   endtask

   // rewrites all six registers; a present write also resets that zone
   task automatic load_tables(input logic [PRES_W-1:0] pa, input logic [63:0] qa,
                              input logic [PRES_W-1:0] pb, input logic [63:0] qb,
                              input logic [PRES_W-1:0] pc, input logic [63:0] qc);
      write_table(REG_A_PRESENT, CSR_DATA_W'(pa));
      write_table(REG_A_PRIO, qa);
      write_table(REG_B_PRESENT, CSR_DATA_W'(pb));
      write_table(REG_B_PRIO, qb);
      write_table(REG_C_PRESENT, CSR_DATA_W'(pc));
      write_table(REG_C_PRIO, qc);
      csr_write <= 1'b0;
      present_copy[0] = pa;
      present_copy[1] = pb;
      present_copy[2] = pc;
   endtask

   // one request: random idle cycles first, then hold until taken;
   // valid stays high afterwards so the next request can follow at once
   task automatic send_request(input op_type op, input logic [ZONE_W-1:0] zone,
                               input logic [FN_W-1:0] sn, input status_type st,
                               input logic flag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= op;
      req_zone        <= zone;
      req_function_sn <= sn;
      req_new_status  <= st;
      req_flag_value  <= flag;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (zone < ZONE_COUNT_DEF) begin
         requests_sent++;
      end
   endtask

   // wait until every request has its response, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [FN_W-1:0] any_fn();
      return FN_W'($urandom_range(0, 16));
   endfunction

   function automatic status_type any_status();
      return status_type'($urandom_range(0, 3));
   endfunction

   // mostly a function present in the zone, sometimes anything in range
   function automatic logic [FN_W-1:0] pick_fn(input int z);
      int i;
      if (present_copy[z] == '0 || $urandom_range(0, 9) == 0) begin
         return any_fn();
      end
      do begin
         i = $urandom_range(0, FUNCS_PER_ZONE_DEF - 1);
      end while (!present_copy[z][i]);
      return FN_W'(i);
   endfunction

   // fully random request, zone past the end included
   task automatic send_noise();
      send_request(op_type'($urandom_range(0, 3)), ZONE_W'($urandom_range(0, 3)),
                   any_fn(), any_status(), 1'($urandom_range(0, 1)));
   endtask

   // a well-formed ownership cycle: make ready, claim, contend, release
   task automatic run_episode(input int z);
      logic [FN_W-1:0] holder;
      logic [ZONE_W-1:0] zn;
      int steps;
      holder = pick_fn(z);
      zn     = ZONE_W'(z);
      steps  = $urandom_range(1, 6);
      send_request(OP_READY, zn, any_fn(), any_status(), 1'($urandom_range(0, 1)));
      send_request(OP_REQUEST, zn, holder, any_status(), 1'($urandom_range(0, 1)));
      repeat (steps) begin
         case ($urandom_range(0, 5))
            // contenders, the more urgent ones mark a preemption
            0, 1: send_request(OP_REQUEST, zn, pick_fn(z), any_status(),
                               1'($urandom_range(0, 1)));
            // the holder asking again sees owner or owner-with-preempt while it still owns the zone
            2: send_request(OP_REQUEST, zn, holder, any_status(), 1'($urandom_range(0, 1)));
            3: send_request(OP_FLAG, zn, any_fn(), any_status(), 1'($urandom_range(0, 1)));
            // status change from a function that is usually not the owner
            4: send_request(OP_STATUS, zn, pick_fn(z), any_status(),
                            1'($urandom_range(0, 1)));
            default: send_noise();
         endcase
      end
      // release, mostly to end so the zone can be made ready again
      if ($urandom_range(0, 3) != 0) begin
         send_request(OP_STATUS, zn, holder, ST_END, 1'($urandom_range(0, 1)));
      end else begin
         send_request(OP_STATUS, zn, holder, any_status(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_random(input int quota);
      int start;
      start = requests_sent;
      while (requests_sent - start < quota) begin
         if ($urandom_range(0, 99) < 15) begin
            send_noise();
         end else begin
            run_episode($urandom_range(0, ZONE_COUNT_DEF - 1));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // a write past the last register must not disturb anything
      write_table(REG_SPARE, '1);
      // zone a: functions 0..7, urgency rises with the function number
      // zone b: all sixteen present, all equally urgent
      // zone c: functions 0 and 15, idle number 16, least urgent everywhere
      load_tables(16'h00FF, 64'h0123_4567_89AB_CDEF,
                  16'hFFFF, 64'h0,
                  16'h8001, '1);

      // directed walk through zone a
      send_request(OP_READY, 0, 0, ST_INIT, 1'b0);     // init to ready
      send_request(OP_READY, 0, 0, ST_INIT, 1'b0);     // already ready, ignored
      send_request(OP_REQUEST, 0, 2, ST_INIT, 1'b0);   // granted, play
      send_request(OP_READY, 0, 0, ST_INIT, 1'b0);     // in play, ignored
      send_request(OP_REQUEST, 0, 2, ST_INIT, 1'b0);   // owner
      send_request(OP_REQUEST, 0, 1, ST_INIT, 1'b0);   // less urgent, busy
      send_request(OP_REQUEST, 0, 7, ST_INIT, 1'b0);   // more urgent, preempt pending
      send_request(OP_REQUEST, 0, 2, ST_INIT, 1'b0);   // owner with preempt pending
      send_request(OP_REQUEST, 0, 12, ST_INIT, 1'b0);  // not in table, unknown
      send_request(OP_REQUEST, 0, 16, ST_INIT, 1'b0);  // outside any table, unknown
      send_request(OP_STATUS, 0, 5, ST_END, 1'b0);     // not owner
      send_request(OP_FLAG, 0, 0, ST_INIT, 1'b0);      // flag cleared
      send_request(OP_FLAG, 0, 31, ST_PLAY, 1'b1);     // flag set
      send_request(OP_STATUS, 0, 2, ST_END, 1'b0);     // owner ends
      send_request(OP_READY, 0, 0, ST_INIT, 1'b0);     // end to ready
      send_request(OP_REQUEST, 0, 16, ST_INIT, 1'b0);  // function 16 takes the ready zone
      send_request(OP_REQUEST, 0, 3, ST_INIT, 1'b0);   // owner not in table, unknown
      send_request(OP_STATUS, 0, 16, ST_INIT, 1'b0);   // owner back to init

      // zone past the end, report code ignored and every other field zero
      send_request(OP_REQUEST, ZONE_NONE, 1, ST_READY, 1'b1);
      send_request(OP_FLAG, ZONE_NONE, 16, ST_END, 1'b1);

      // zone b: equal urgency never preempts
      send_request(OP_READY, 1, 0, ST_INIT, 1'b0);
      send_request(OP_REQUEST, 1, 15, ST_INIT, 1'b0);
      send_request(OP_REQUEST, 1, 0, ST_INIT, 1'b0);
      send_request(OP_STATUS, 1, 15, ST_READY, 1'b0);  // owner hands back to ready
      send_request(OP_REQUEST, 1, 3, ST_INIT, 1'b0);

      // zone c in init: owner is the idle number, so unknown
      send_request(OP_REQUEST, 2, 0, ST_INIT, 1'b0);
      settle();

      // sender idles a third of the time, receiver half
      send_idle_pct <= 33;
      stall_pct     <= 50;
      load_tables(16'hFFFF, {$urandom, $urandom},
                  16'($urandom), 64'h0,
                  16'h0001, {$urandom, $urandom});
      run_random(RANDOM_PER_PHASE);
      settle();

      // the other way round, zone a least urgent everywhere
      send_idle_pct <= 50;
      stall_pct     <= 33;
      load_tables(16'($urandom), '1,
                  16'hFFFF, {$urandom, $urandom},
                  16'h8000, {$urandom, $urandom});
      run_random(RANDOM_PER_PHASE);
      settle();

      // full rate on both sides, zone c with an empty table
      send_idle_pct <= 0;
      stall_pct     <= 0;
      load_tables(16'($urandom), {$urandom, $urandom},
                  16'($urandom), {$urandom, $urandom},
                  16'h0000, {$urandom, $urandom});
      run_random(RANDOM_PER_PHASE);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d zone requests, %0d reports checked over four table settings",
               requests_sent, checked);
      $display("run: report codes seen, one bit per code from the top: %b", codes_seen);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/zppa_pkg.sv
sv/zppa_ctrl.sv
sv/zppa_dpath.sv
sv/zone_priority_preempt_arbiter.sv
tb/sv/zone_owner_checker.sv
tb/sv/zone_priority_preempt_arbiter_tb.sv
